>>> rtl/core/cqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_pkg - circular queue with search, shared types and constants
// Operation and status codes, sequencer states, cell control bundle.
// ----------------------------------------------------------------------------
package cqs_pkg;

	localparam int WORD_W    = 32;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	// fan-in of one group in the registered OR tree
	localparam int OR_GROUP  = 64;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DEQ  = 2'd1,
		KIND_SRCH = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_GRP  = 2'd1,
		S_FIN  = 2'd2
	} state_t;

	// strobes broadcast to every cell, already qualified
	typedef struct packed {
		logic enq;
		logic deq;
		logic srch;
	} cell_ctrl_t;

endpackage

>>> rtl/core/cqs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_req_if - request channel
// valid/ready channel carrying one queue operation.
// ----------------------------------------------------------------------------
interface cqs_req_if;
	logic                               valid;
	logic                               ready;
	logic [cqs_pkg::KIND_W-1:0]         kind;
	logic signed [cqs_pkg::WORD_W-1:0]  value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

>>> rtl/core/cqs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_rsp_if - response channel
// valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface cqs_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [cqs_pkg::STATUS_W-1:0]       status;
	logic signed [cqs_pkg::WORD_W-1:0]  data;
	logic                               found;

	modport source (output valid, output status, output data, output found, input ready);
	modport sink   (input valid, input status, input data, input found, output ready);
endinterface

>>> rtl/core/cqs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_cell - one queue slot
// Holds one word; loads on enqueue at its position, takes its neighbor's word
// on dequeue, and registers its own key match on search.
// ----------------------------------------------------------------------------
module cqs_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 8
) (
	input  logic                clk,
	input  cqs_pkg::cell_ctrl_t ctrl,
	input  logic [CNT_W-1:0]    cnt,
	input  cqs_pkg::word_t      value,
	input  cqs_pkg::word_t      nbr_data,
	output cqs_pkg::word_t      data_q,
	output logic                match_q
);

	logic occupied;

	assign occupied = (CNT_W'(IDX) < cnt);

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			data_q <= nbr_data;
		end else if (ctrl.enq && (cnt == CNT_W'(IDX))) begin
			data_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.srch) begin
			match_q <= occupied && (data_q == value);
		end
	end

endmodule

>>> rtl/core/cqs_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_or_tree - registered OR reduction
// First level ORs groups of match bits into registers; second level is
// combinational over the group registers.
// ----------------------------------------------------------------------------
module cqs_or_tree #(
	parameter int N = 128
) (
	input  logic         clk,
	input  logic         load,
	input  logic [N-1:0] bits,
	output logic         any
);

	localparam int NGRP = (N + cqs_pkg::OR_GROUP - 1) / cqs_pkg::OR_GROUP;

	logic [NGRP*cqs_pkg::OR_GROUP-1:0] pad;
	logic [NGRP-1:0]                   grp_d;
	logic [NGRP-1:0]                   grp_q;

	always_comb begin
		pad        = '0;
		pad[N-1:0] = bits;
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = |pad[g*cqs_pkg::OR_GROUP +: cqs_pkg::OR_GROUP];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp_d;
		end
	end

	assign any = |grp_q;

endmodule

>>> rtl/core/circular_queue_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_search_core - FIFO of signed words with key search
// Enqueue, dequeue and membership search over a row of DEPTH slot cells.
// ----------------------------------------------------------------------------
// Results: enqueue, dequeue and unused codes respond in the cycle after the
//   transaction; a search on a non-empty queue passes cell match, OR-group
//   and response registers. Throughput: one enqueue/dequeue per cycle while
//   responses are taken; no request is taken while a search is under way.
// Reset: occupancy cleared (queue empty), sequencer idle, response empty.
//   Slot storage is not cleared; only occupied cells are ever observed.
// ----------------------------------------------------------------------------
module circular_queue_with_search_core #(
	parameter int DEPTH = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	cqs_req_if.sink         req,
	cqs_rsp_if.source       rsp
);

	// count holds 0..DEPTH
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Queue organization: cell 0 always holds the oldest word. A dequeue
	// shifts every cell one step toward cell 0; an enqueue writes the cell
	// whose index equals the current count. Head/tail pointers collapse into
	// the single occupancy count.

	cqs_pkg::state_t       state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	cqs_pkg::cell_ctrl_t   ctrl;
	cqs_pkg::kind_t        kind;
	logic                  accept;
	logic                  full, empty;

	cqs_pkg::word_t        cell_data [DEPTH];
	logic [DEPTH-1:0]      match;
	logic                  tree_load;
	logic                  any_hit;

	// response register
	logic                  out_valid_q;
	cqs_pkg::status_t      out_status_q;
	cqs_pkg::word_t        out_data_q;
	logic                  out_found_q;
	logic                  out_free;
	logic                  out_load;
	cqs_pkg::status_t      out_status_d;
	cqs_pkg::word_t        out_data_d;
	logic                  out_found_d;

	assign kind     = cqs_pkg::kind_t'(req.kind);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	// ------------------------------------------------------------------------
	// Sequencer: next state, ready, cell strobes and response load
	// ------------------------------------------------------------------------
	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		ctrl         = '0;
		tree_load    = 1'b0;
		out_load     = 1'b0;
		out_status_d = cqs_pkg::ST_OK;
		out_data_d   = '0;
		out_found_d  = 1'b0;
		case (state_q)
			cqs_pkg::S_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					case (kind)
						cqs_pkg::KIND_ENQ: begin
							out_load = 1'b1;
							if (full) begin
								out_status_d = cqs_pkg::ST_OVER;
							end else begin
								ctrl.enq = 1'b1;
							end
						end
						cqs_pkg::KIND_DEQ: begin
							out_load = 1'b1;
							if (empty) begin
								out_status_d = cqs_pkg::ST_UNDER;
							end else begin
								ctrl.deq   = 1'b1;
								out_data_d = cell_data[0];
							end
						end
						cqs_pkg::KIND_SRCH: begin
							if (empty) begin
								out_load     = 1'b1;
								out_status_d = cqs_pkg::ST_UNDER;
							end else begin
								// cells register their match bits at this edge
								ctrl.srch = 1'b1;
								state_d   = cqs_pkg::S_GRP;
							end
						end
						default: begin
							// unused code: ok, nothing changes
							out_load = 1'b1;
						end
					endcase
				end
			end
			cqs_pkg::S_GRP: begin
				tree_load = 1'b1;
				state_d   = cqs_pkg::S_FIN;
			end
			cqs_pkg::S_FIN: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_found_d = any_hit;
					state_d     = cqs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cqs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cqs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.enq) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.deq) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// ------------------------------------------------------------------------
	// Row of slot cells; the last cell keeps its own word on a shift
	// ------------------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cqs_pkg::word_t nbr;
		if (i == DEPTH - 1) begin : g_last
			assign nbr = cell_data[i];
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		cqs_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.cnt      (count_q),
			.value    (req.value),
			.nbr_data (nbr),
			.data_q   (cell_data[i]),
			.match_q  (match[i])
		);
	end

	// match bits reduced by a registered group level and a combinational final OR
	cqs_or_tree #(
		.N (DEPTH)
	) u_or_tree (
		.clk  (clk),
		.load (tree_load),
		.bits (match),
		.any  (any_hit)
	);

	// ------------------------------------------------------------------------
	// Response register: decouples the result from the request side
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_data_q   <= out_data_d;
			out_found_q  <= out_found_d;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.data   = out_data_q;
	assign rsp.found  = out_found_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy above DEPTH");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == cqs_pkg::KIND_ENQ && !full)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("enqueue did not bump occupancy");

	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cqs_pkg::S_FIN) |-> !out_valid_q)
		else $error("search result would wait behind an older response");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> rsp.status == cqs_pkg::ST_OK)
		else $error("found flagged with error status");

	a_srch_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cqs_pkg::S_GRP || state_q == cqs_pkg::S_FIN) |-> !req.ready)
		else $error("request taken during search");

endmodule

>>> dv/tb_circular_queue_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_queue_with_search_core - queue/search core testbench
// Drives enqueue, dequeue, search and the unused code through the request
// channel, mirrors the queue in a shadow copy and checks every response in
// order. A short table covers empty, extreme and error cases. Random phases
// then fill the queue to overflow, wrap it, search it and drain it, under
// random idling on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_search_core;

	localparam int          DEPTH       = 128;
	localparam int          LIMIT       = 200000;  // cycles before giving up
	localparam int          HOLD_CYCLES = 80;      // long response hold-off
	localparam int          SETTLE      = 10;      // idle wait before the verdict
	localparam int          DIR_N       = 22;
	// kind code with no operation behind it
	localparam logic [cqs_pkg::KIND_W-1:0] KIND_RSVD = 2'd3;
	localparam cqs_pkg::word_t W_MAX    = 32'sh7FFFFFFF;
	localparam cqs_pkg::word_t W_MIN    = 32'sh80000000;

	typedef struct {
		cqs_pkg::status_t status;
		cqs_pkg::word_t   data;
		logic             found;
	} outcome_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct {
		logic [cqs_pkg::KIND_W-1:0] kind;
		cqs_pkg::word_t             value;
		bit                         typed;
		outcome_t                   want;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cqs_req_if req_ch ();
	cqs_rsp_if rsp_ch ();

	circular_queue_with_search_core #(
		.DEPTH (DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	// shadow of the queue contents, oldest word at the front
	cqs_pkg::word_t shadow_words[$];
	// responses still owed by the core, oldest first
	outcome_t    pending_results[$];
	int unsigned bad_count    = 0;
	int unsigned rsp_index    = 0;
	int unsigned cycle_count  = 0;
	bit          squeeze_rsp  = 1'b0;  // ask the sink for the long hold-off
	bit          squeeze_done = 1'b0;
	bit          quiet_tail   = 1'b0;  // no idling on either side from here on

	// Directed table: empty-queue errors, the unused code, extreme words,
	// dequeue order, search after dequeue and search on an emptied queue
	// whose slots still hold stale words.
	op_row_t directed_rows [DIR_N] = '{
		'{cqs_pkg::KIND_SRCH, 32'sd0,        1'b1, '{cqs_pkg::ST_UNDER, 32'sd0, 1'b0}},
		'{cqs_pkg::KIND_DEQ,  32'sd0,        1'b1, '{cqs_pkg::ST_UNDER, 32'sd0, 1'b0}},
		'{KIND_RSVD,          32'sh5A5A5A5A, 1'b1, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_ENQ,  W_MAX,         1'b1, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_ENQ,  W_MIN,         1'b1, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_ENQ,  32'sd0,        1'b1, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_ENQ,  -32'sd1,       1'b1, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_SRCH, W_MIN,         1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_SRCH, 32'sh7FFFFFFE, 1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_SRCH, -32'sd1,       1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{KIND_RSVD,          32'sd0,        1'b1, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_DEQ,  32'sd0,        1'b1, '{cqs_pkg::ST_OK,    W_MAX,  1'b0}},
		'{cqs_pkg::KIND_DEQ,  -32'sd1,       1'b1, '{cqs_pkg::ST_OK,    W_MIN,  1'b0}},
		'{cqs_pkg::KIND_SRCH, W_MAX,         1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_DEQ,  32'sd0,        1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_DEQ,  32'sd0,        1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_DEQ,  32'sd0,        1'b1, '{cqs_pkg::ST_UNDER, 32'sd0, 1'b0}},
		'{cqs_pkg::KIND_SRCH, -32'sd1,       1'b1, '{cqs_pkg::ST_UNDER, 32'sd0, 1'b0}},
		'{cqs_pkg::KIND_ENQ,  32'sh55555555, 1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_SRCH, 32'shAAAAAAAA, 1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_ENQ,  32'shAAAAAAAA, 1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}},
		'{cqs_pkg::KIND_SRCH, 32'shAAAAAAAA, 1'b0, '{cqs_pkg::ST_OK,    32'sd0, 1'b0}}
	};

	// Apply one operation to the shadow queue and return the response the
	// core owes for it. Full/empty checks come first; errors leave the
	// shadow untouched. A search looks at every word still queued.
	function automatic outcome_t apply_queue_op(input logic [cqs_pkg::KIND_W-1:0] k,
			input cqs_pkg::word_t v);
		outcome_t o;
		o = '{cqs_pkg::ST_OK, 32'sd0, 1'b0};
		if (k == cqs_pkg::KIND_ENQ) begin
			if (shadow_words.size() >= DEPTH)
				o.status = cqs_pkg::ST_OVER;
			else
				shadow_words.push_back(v);
		end else if (k == cqs_pkg::KIND_DEQ) begin
			if (shadow_words.size() == 0)
				o.status = cqs_pkg::ST_UNDER;
			else
				o.data = shadow_words.pop_front();
		end else if (k == cqs_pkg::KIND_SRCH) begin
			if (shadow_words.size() == 0)
				o.status = cqs_pkg::ST_UNDER;
			else
				foreach (shadow_words[i])
					if (shadow_words[i] == v)
						o.found = 1'b1;
		end
		// reserved code: ok, zeros, no state change
		return o;
	endfunction

	// extremes, a narrow band around zero (repeats make hits likely), or
	// any 32-bit pattern
	function automatic cqs_pkg::word_t rand_word();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: return W_MAX;
					1: return W_MIN;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			1: return cqs_pkg::word_t'($urandom_range(0, 15)) - 32'sd8;
			default: return cqs_pkg::word_t'($urandom());
		endcase
	endfunction

	// Present one transaction and hold it until the core takes it; the
	// expectation is queued at the accepting edge.
	task automatic issue_op(input logic [cqs_pkg::KIND_W-1:0] k, input cqs_pkg::word_t v,
			input bit typed, input outcome_t want);
		outcome_t predicted;
		req_ch.valid <= 1'b1;
		req_ch.kind  <= k;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_queue_op(k, v);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// random sender idle burst
	task automatic sender_gap();
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every owed response has been taken.
	// Polling on the falling edge keeps clear of the monitor's pop.
	task automatic drain_queue_rsp();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Random phase with weighted operation mix. Search keys are taken
	// from the queued words half the time so hits are common.
	// The first steady_n transactions go out back to back.
	task automatic run_phase(input int unsigned count, input int unsigned enq_w,
			input int unsigned deq_w, input int unsigned srch_w,
			input int unsigned rsvd_w, input int unsigned steady_n);
		int unsigned                r;
		logic [cqs_pkg::KIND_W-1:0] k;
		cqs_pkg::word_t             v;
		for (int unsigned n = 0; n < count; n++) begin
			r = $urandom_range(0, enq_w + deq_w + srch_w + rsvd_w - 1);
			if (r < enq_w)
				k = cqs_pkg::KIND_ENQ;
			else if (r < enq_w + deq_w)
				k = cqs_pkg::KIND_DEQ;
			else if (r < enq_w + deq_w + srch_w)
				k = cqs_pkg::KIND_SRCH;
			else
				k = KIND_RSVD;
			if (k == cqs_pkg::KIND_SRCH && shadow_words.size() != 0 &&
					$urandom_range(0, 1) == 1)
				v = shadow_words[$urandom_range(0, shadow_words.size() - 1)];
			else
				v = rand_word();
			if (n >= steady_n)
				sender_gap();
			issue_op(k, v, 1'b0, '{cqs_pkg::ST_OK, 32'sd0, 1'b0});
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind  = cqs_pkg::KIND_ENQ;
		req_ch.value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			sender_gap();
			issue_op(directed_rows[i].kind, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].want);
		end
		drain_queue_rsp();

		// light mixed traffic on a near-empty queue
		run_phase(30, 4, 4, 3, 1, 0);
		drain_queue_rsp();

		// Fill past full: the sink holds off for a long stretch while the
		// first 40 transactions go out back to back, so the core backs up
		// and stalls the request side. Later enqueues wrap the tail and hit
		// overflow; searches then span the wrapped queue.
		squeeze_rsp <= 1'b1;
		run_phase(170, 90, 3, 6, 1, 40);

		// mostly dequeues: wraps the head and drains toward underflow
		run_phase(170, 5, 80, 13, 2, 0);
		drain_queue_rsp();

		// closing stretch, no idling on either side
		quiet_tail <= 1'b1;
		run_phase(40, 4, 4, 3, 1, 0);
		drain_queue_rsp();
		repeat (SETTLE) @(posedge clk);

		if (bad_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Response sink: random stall bursts, plus one long hold-off when
	// asked for. Each branch updates ready once per edge.
	// ------------------------------------------------------------------
	initial begin : rsp_sink
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (squeeze_rsp && !squeeze_done) begin
				squeeze_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response checker: in-order compare against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rsp_check
		outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected response #%0d: status=%0d data=%0d found=%0d",
						rsp_index, rsp_ch.status, rsp_ch.data, rsp_ch.found);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.data !== want.data ||
						rsp_ch.found !== want.found) begin
					bad_count++;
					if (bad_count <= 10) begin
						$display("response #%0d mismatch: expected status=%0d data=%0d found=%0d",
							rsp_index, want.status, want.data, want.found);
						$display("    got status=%0d data=%0d found=%0d",
							rsp_ch.status, rsp_ch.data, rsp_ch.found);
					end
				end
			end
			rsp_index++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				LIMIT, pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

>>> circular_queue_with_search_core.f
rtl/core/cqs_pkg.sv
rtl/core/cqs_req_if.sv
rtl/core/cqs_rsp_if.sv
rtl/core/cqs_cell.sv
rtl/core/cqs_or_tree.sv
rtl/core/circular_queue_with_search_core.sv
dv/tb_circular_queue_with_search_core.sv
